### src/tpba_pkg.sv
`default_nettype none
package tpba_pkg;

   // Pool sizes
   localparam int CMD_POOL  = 16;
   localparam int DATA_POOL = 16;

   // Store geometry
   localparam int SLOTS   = 32;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int LINK_W  = SLOT_W + 1;
   localparam int CMD_CNT = (CMD_POOL > SLOTS) ? SLOTS : CMD_POOL;
   localparam int TOTAL_CNT =
      ((CMD_POOL + DATA_POOL) > SLOTS) ? SLOTS : (CMD_POOL + DATA_POOL);

   // End-of-list mark: any link with its top bit set ends the list
   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);

   // Reset values of the pool heads
   localparam logic [SLOT_W-1:0] CMD_HEAD_RST  = SLOT_W'(CMD_CNT - 1);
   localparam logic [SLOT_W-1:0] DATA_HEAD_RST =
      SLOT_W'((TOTAL_CNT > CMD_CNT) ? (TOTAL_CNT - 1) : 0);
   localparam logic              DATA_VALID_RST = (TOTAL_CNT > CMD_CNT);

   // Request kinds
   localparam logic [1:0] OP_ALLOC_CMD  = 2'd0;
   localparam logic [1:0] OP_ALLOC_DATA = 2'd1;
   localparam logic [1:0] OP_FREE       = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_FREED      = 3'd2;
   localparam logic [2:0] ST_NOT_IN_USE = 3'd3;
   localparam logic [2:0] ST_IGNORED    = 3'd4;

   // Link held by an entry that has not been written since reset
   function automatic logic [LINK_W-1:0] reset_link(input logic [SLOT_W-1:0] idx);
      logic [LINK_W-1:0] r;
      if (idx == '0 || {1'b0, idx} == LINK_W'(CMD_CNT) ||
          {1'b0, idx} >= LINK_W'(TOTAL_CNT)) begin
         r = LINK_END;
      end else begin
         r = {1'b0, idx - SLOT_W'(1)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/tpba_ram.sv
`default_nettype none
module tpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the word while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/two_pool_buffer_allocator_core.sv
`default_nettype none
// A request word is latched, and the link of its pool head read, as it is accepted; the result
// word is registered in the execute state once the output is free. No new request is taken
// until then, as the read of the link memory precedes the write-back of each request.
// Reset: heads, link valid bits and in-use marks return at once; there is no clearing
// pass, so requests are taken in the first cycle after reset.
module two_pool_buffer_allocator_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [5:0] handle, [7:6] zero
   input  wire logic [1:0] req_tuser,   // [1:0] command
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [4:0] granted_handle, [7:5] zero
   output logic      [2:0] rsp_tuser    // [2:0] status
);

   localparam int SW = tpba_pkg::SLOT_W;
   localparam int LW = tpba_pkg::LINK_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]                   op_ff;
   logic [5:0]                   handle_ff;
   logic [SW-1:0]                cmd_head_ff, cmd_head_in;
   logic                         cmd_vld_ff, cmd_vld_in;
   logic [SW-1:0]                data_head_ff, data_head_in;
   logic                         data_vld_ff, data_vld_in;
   logic [tpba_pkg::SLOTS-1:0]   link_vld_ff, link_vld_in;
   logic [tpba_pkg::SLOTS-1:0]   in_use_ff, in_use_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic [SW-1:0]                rsp_handle_ff, rsp_handle_in;

   logic          accept;
   logic          out_free;
   logic          done;
   logic          ram_we;
   logic [SW-1:0] ram_waddr;
   logic [LW-1:0] ram_wdata;
   logic [SW-1:0] ram_raddr;
   logic [LW-1:0] ram_rdata;
   logic          alloc_data;
   logic [SW-1:0] sel_head;
   logic          sel_vld;
   logic [LW-1:0] link_cur;
   logic [SW-1:0] hslot;
   logic          is_cmd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Read the link of the chosen pool's head as the word is taken
   assign ram_raddr = (req_tuser == tpba_pkg::OP_ALLOC_DATA) ? data_head_ff : cmd_head_ff;

   tpba_ram #(
      .WIDTH (LW),
      .DEPTH (tpba_pkg::SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Heads are stable between accept and execute, so the pool is picked again here
   assign alloc_data = (op_ff == tpba_pkg::OP_ALLOC_DATA);
   assign sel_head   = alloc_data ? data_head_ff : cmd_head_ff;
   assign sel_vld    = alloc_data ? data_vld_ff : cmd_vld_ff;
   assign link_cur   = link_vld_ff[sel_head] ? ram_rdata : tpba_pkg::reset_link(sel_head);
   assign hslot      = handle_ff[SW-1:0];
   assign is_cmd     = ({1'b0, hslot} < LW'(tpba_pkg::CMD_CNT));

   // Execute: modify the pool state and write the link back
   always_comb begin
      state_in      = state_ff;
      cmd_head_in   = cmd_head_ff;
      cmd_vld_in    = cmd_vld_ff;
      data_head_in  = data_head_ff;
      data_vld_in   = data_vld_ff;
      link_vld_in   = link_vld_ff;
      in_use_in     = in_use_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      ram_we        = 1'b0;
      ram_waddr     = sel_head;
      ram_wdata     = tpba_pkg::LINK_END;
      done          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               done          = 1'b1;
               state_in      = S_IDLE;
               rsp_handle_in = '0;
               if (op_ff == tpba_pkg::OP_ALLOC_CMD || op_ff == tpba_pkg::OP_ALLOC_DATA) begin
                  if (!sel_vld) begin
                     rsp_status_in = tpba_pkg::ST_EMPTY;
                  end else begin
                     // Pop the head; a link with its top bit set empties the pool
                     if (alloc_data) begin
                        if (link_cur[LW-1]) data_vld_in = 1'b0;
                        else                data_head_in = link_cur[SW-1:0];
                     end else begin
                        if (link_cur[LW-1]) cmd_vld_in = 1'b0;
                        else                cmd_head_in = link_cur[SW-1:0];
                     end
                     ram_we                = 1'b1;
                     ram_waddr             = sel_head;
                     ram_wdata             = tpba_pkg::LINK_END;
                     link_vld_in[sel_head] = 1'b1;
                     in_use_in[sel_head]   = 1'b1;
                     rsp_status_in         = tpba_pkg::ST_GRANTED;
                     rsp_handle_in         = sel_head;
                  end
               end else if (op_ff != tpba_pkg::OP_FREE ||
                            handle_ff >= 6'(tpba_pkg::TOTAL_CNT)) begin
                  rsp_status_in = tpba_pkg::ST_IGNORED;
               end else if (!in_use_ff[hslot]) begin
                  rsp_status_in = tpba_pkg::ST_NOT_IN_USE;
               end else begin
                  // Push the buffer onto its own pool
                  in_use_in[hslot]   = 1'b0;
                  ram_we             = 1'b1;
                  ram_waddr          = hslot;
                  link_vld_in[hslot] = 1'b1;
                  if (is_cmd) begin
                     ram_wdata   = cmd_vld_ff ? {1'b0, cmd_head_ff} : tpba_pkg::LINK_END;
                     cmd_head_in = hslot;
                     cmd_vld_in  = 1'b1;
                  end else begin
                     ram_wdata    = data_vld_ff ? {1'b0, data_head_ff} : tpba_pkg::LINK_END;
                     data_head_in = hslot;
                     data_vld_in  = 1'b1;
                  end
                  rsp_status_in = tpba_pkg::ST_FREED;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_head_ff  <= tpba_pkg::CMD_HEAD_RST;
         cmd_vld_ff   <= 1'b1;
         data_head_ff <= tpba_pkg::DATA_HEAD_RST;
         data_vld_ff  <= tpba_pkg::DATA_VALID_RST;
         link_vld_ff  <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_head_ff  <= cmd_head_in;
         cmd_vld_ff   <= cmd_vld_in;
         data_head_ff <= data_head_in;
         data_vld_ff  <= data_vld_in;
         link_vld_ff  <= link_vld_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result words
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_tuser;
         handle_ff <= req_tdata[5:0];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_handle_ff};

endmodule
`default_nettype wire
